// ===== rtl/core/pau_pkg.sv =====
// Shared types and constants for the pixel art upscaler.
package pau_pkg;

   localparam logic [1:0] MODE_SCALE2X = 2'd0;
   localparam logic [1:0] MODE_SCALE3X = 2'd1;
   localparam logic [1:0] MODE_EAGLE2X = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   // One centre to expand: neighborhood A..I, position, scale and end flag.
   typedef struct packed {
      logic [8:0][31:0] nb;
      logic [11:0]      cx;
      logic [11:0]      cy;
      logic [1:0]       mode;
      logic             last;
   } job_type;

endpackage

// ===== rtl/core/pau_ram.sv =====
// Generic single-port-write, registered-read RAM.
module pau_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/core/pau_front.sv =====
// Front end: line stores, window, position counters and centre job generation.
module pau_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [31:0]     req_pixel_in,
   input  logic            cfg_restart,
   input  logic [1:0]      mode,
   input  logic [10:0]     image_width,
   input  logic [10:0]     image_height,
   output logic            job_valid,
   output pau_pkg::job_type job,
   input  logic            job_full,
   output logic            busy
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);

   logic [CW-1:0] w_eff, col_ff, col_in, c;
   logic [RW-1:0] h_eff, row_ff, row_in, r;

   always_comb begin
      if (image_width == '0) w_eff = CW'(1);
      else if ({21'd0, image_width} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(image_width);
      if (image_height == '0) h_eff = RW'(1);
      else if ({21'd0, image_height} > 32'(MAX_HEIGHT)) h_eff = RW'(MAX_HEIGHT);
      else h_eff = RW'(image_height);
      c = (col_ff >= w_eff) ? w_eff - CW'(1) : col_ff;
      r = (row_ff >= h_eff) ? h_eff - RW'(1) : row_ff;
   end

   // Stage 0 accepts and reads line stores; stage 1 updates window and emits jobs.
   logic            s1_ff;
   logic            first_ff; // first cycle in stage 1 (window not yet shifted)
   logic [31:0]     p1_ff;
   logic [CW-1:0]   c1_ff;
   logic [RW-1:0]   r1_ff;
   logic [31:0]     above_q, two_q;
   logic [2:0]      pend_ff; // remaining centre kinds to emit
   logic            accept;

   assign req_stall = s1_ff;
   assign accept    = req_valid && !s1_ff;
   assign busy      = s1_ff;

   pau_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_above (
      .clock(clock), .wr_en(s1_ff && first_ff), .wr_addr(c1_ff[AW-1:0]),
      .wr_data(p1_ff), .rd_addr(c[AW-1:0]), .rd_data(above_q));
   pau_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_two (
      .clock(clock), .wr_en(s1_ff && first_ff && r1_ff != '0),
      .wr_addr(c1_ff[AW-1:0]), .wr_data(above_q), .rd_addr(c[AW-1:0]), .rd_data(two_q));

   logic [2:0][2:0][31:0] win_ff, win_in; // [col][row]
   logic [31:0] a, b;
   logic have0, have1, have2, have3;
   logic lastc, lastr;

   always_comb begin
      b = (r1_ff != '0) ? above_q : p1_ff;
      a = (r1_ff >= RW'(2)) ? two_q : b;
      lastc = c1_ff == w_eff - CW'(1);
      lastr = r1_ff == h_eff - RW'(1);
      have0 = r1_ff != '0 && c1_ff != '0;
      have1 = r1_ff != '0 && lastc;
      have2 = lastr && c1_ff != '0;
      have3 = lastr && lastc;
   end

   always_comb begin
      win_in = win_ff;
      if (s1_ff && first_ff) begin
         if (c1_ff == '0) begin
            for (int k = 0; k < 3; k++) win_in[k] = {p1_ff, b, a};
         end else begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = {p1_ff, b, a};
         end
      end
   end

   logic [2:0][2:0][31:0] wv;
   assign wv = first_ff ? win_in : win_ff;

   // kind 3 pending after the first cycle is kept in its own flag
   logic k3_ff;
   logic [3:0] todo_all;
   assign todo_all = first_ff ? {have3, have2, have1, have0} : {k3_ff, pend_ff};
   logic [1:0] kd;
   logic [3:0] rest_all;
   always_comb begin
      if (todo_all[0]) kd = 2'd0;
      else if (todo_all[1]) kd = 2'd1;
      else if (todo_all[2]) kd = 2'd2;
      else kd = 2'd3;
      rest_all = todo_all & ~(4'd1 << kd);
   end

   logic [1:0] lc, mc, rc, tr, mr, br;
   always_comb begin
      lc = (kd[0]) ? 2'd1 : 2'd0;
      mc = (kd[0]) ? 2'd2 : 2'd1;
      rc = 2'd2;
      tr = (kd[1]) ? 2'd1 : 2'd0;
      mr = (kd[1]) ? 2'd2 : 2'd1;
      br = 2'd2;
      job.nb[0] = wv[lc][tr]; job.nb[1] = wv[mc][tr]; job.nb[2] = wv[rc][tr];
      job.nb[3] = wv[lc][mr]; job.nb[4] = wv[mc][mr]; job.nb[5] = wv[rc][mr];
      job.nb[6] = wv[lc][br]; job.nb[7] = wv[mc][br]; job.nb[8] = wv[rc][br];
      job.cx   = 12'(c1_ff) - (kd[0] ? 12'd0 : 12'd1);
      job.cy   = 12'(r1_ff) - (kd[1] ? 12'd0 : 12'd1);
      job.mode = mode;
      job.last = rest_all == '0;
   end

   assign job_valid = s1_ff && todo_all != '0 && !job_full;
   logic done;
   assign done = s1_ff && (todo_all == '0 || (!job_full && rest_all == '0));

   always_comb begin
      if (c + CW'(1) >= w_eff) begin
         col_in = '0;
         row_in = (r + RW'(1) >= h_eff) ? '0 : r + RW'(1);
      end else begin
         col_in = c + CW'(1);
         row_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0; first_ff <= 1'b0; pend_ff <= 3'd0; k3_ff <= 1'b0;
         col_ff <= '0; row_ff <= '0; win_ff <= '0;
      end else begin
         win_ff <= win_in;
         if (cfg_restart) begin
            col_ff <= '0; row_ff <= '0;
         end else if (accept) begin
            col_ff <= col_in; row_ff <= row_in;
         end
         if (accept) begin
            s1_ff <= 1'b1; first_ff <= 1'b1;
         end else if (done) begin
            s1_ff <= 1'b0; first_ff <= 1'b0;
         end else if (s1_ff && job_valid) begin
            pend_ff <= rest_all[2:0]; k3_ff <= rest_all[3]; first_ff <= 1'b0;
         end else if (s1_ff && first_ff) begin
            pend_ff <= todo_all[2:0]; k3_ff <= todo_all[3]; first_ff <= 1'b0;
         end
      end
      if (accept) begin
         p1_ff <= req_pixel_in; c1_ff <= c; r1_ff <= r;
      end
   end
endmodule

// ===== rtl/core/pau_queue.sv =====
// Short job queue between front and back.
module pau_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pau_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output pau_pkg::job_type head
);
   localparam int PW = $clog2(DEPTH);
   pau_pkg::job_type buf_ff [DEPTH];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [PW:0]   cnt_ff;

   assign full = cnt_ff == (PW+1)'(DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head = buf_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == PW'(DEPTH-1)) ? '0 : wp_ff + PW'(1);
         if (pop) rp_ff <= (rp_ff == PW'(DEPTH-1)) ? '0 : rp_ff + PW'(1);
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
      if (push) buf_ff[wp_ff] <= push_data;
   end
endmodule

// ===== rtl/core/pau_back.sv =====
// Back end: expands one centre into its output pixels, one per cycle while rsp_stall allows.
module pau_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_ready,
   input  pau_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [11:0]      rsp_out_x,
   output logic [11:0]      rsp_out_y,
   output logic [31:0]      rsp_pixel_out,
   output logic             rsp_last,
   output logic             idle
);
   logic [31:0] A, B, C, D, E, F, G, H, I;
   logic [8:0][31:0] px;
   logic [1:0] s;
   logic [1:0] i_ff, j_ff;
   logic pre, db, bf, dh, hf;

   always_comb begin
      {I, H, G, F, E, D, C, B, A} = job.nb;
      pre = (B != H) && (D != F);
      db = D == B; bf = B == F; dh = D == H; hf = H == F;
      px = '0;
      s = 2'd2;
      case (job.mode)
         pau_pkg::MODE_SCALE3X: begin
            s = 2'd3;
            px[0] = (pre && db) ? D : E;
            px[1] = (pre && ((db && E != C) || (bf && E != A))) ? B : E;
            px[2] = (pre && bf) ? F : E;
            px[3] = (pre && ((db && E != G) || (dh && E != A))) ? D : E;
            px[4] = E;
            px[5] = (pre && ((bf && E != I) || (hf && E != C))) ? F : E;
            px[6] = (pre && dh) ? D : E;
            px[7] = (pre && ((dh && E != I) || (hf && E != G))) ? H : E;
            px[8] = (pre && hf) ? F : E;
         end
         pau_pkg::MODE_EAGLE2X: begin
            px[0] = (D == A && B == A) ? A : E;
            px[1] = (B == C && F == C) ? C : E;
            px[2] = (D == G && H == G) ? G : E;
            px[3] = (F == I && H == I) ? I : E;
         end
         default: begin
            px[0] = (pre && db) ? D : E;
            px[1] = (pre && bf) ? F : E;
            px[2] = (pre && dh) ? D : E;
            px[3] = (pre && hf) ? F : E;
         end
      endcase
   end

   logic out_free, end_blk, fire;
   logic [3:0] idx;
   assign out_free = !rsp_valid || !rsp_stall;
   assign fire = job_ready && out_free;
   assign end_blk = (i_ff == s - 2'd1) && (j_ff == s - 2'd1);
   assign job_pop = fire && end_blk;
   assign idx = 4'(j_ff) * 4'(s) + 4'(i_ff);
   assign idle = !rsp_valid && !job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0; i_ff <= '0; j_ff <= '0;
      end else begin
         if (out_free) rsp_valid <= job_ready;
         if (fire) begin
            if (i_ff == s - 2'd1) begin
               i_ff <= '0;
               j_ff <= end_blk ? 2'd0 : j_ff + 2'd1;
            end else i_ff <= i_ff + 2'd1;
         end
      end
      if (fire) begin
         rsp_out_x     <= 12'(job.cx * 12'(s)) + 12'(i_ff);
         rsp_out_y     <= 12'(job.cy * 12'(s)) + 12'(j_ff);
         rsp_pixel_out <= px[idx];
         rsp_last      <= job.last && end_blk;
      end
   end
endmodule

// ===== rtl/core/pixel_art_upscaler_unit.sv =====
// Pixel art upscaler (Scale2x, Scale3x, Eagle2x) top level.
// Takes raster-order source pixels and emits the 2x2 or 3x3 output pixels of each centre
// with destination coordinates, one output beat per cycle unless rsp_stall holds it,
// lagging one row and one column. Results of one source beat end with rsp_last. A centre
// yields 4 output pixels in 2x modes and 9 in Scale3x, one per cycle from the back end; on
// the right column and bottom row a source beat can yield up to four centres. The front end
// reads the line stores, then updates the window and emits jobs before the next beat; a
// two-entry queue decouples it. A mode, width or height write restarts at row 0, column 0.
module pixel_art_upscaler_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_out_x,
   output logic [11:0] rsp_out_y,
   output logic [31:0] rsp_pixel_out,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   logic [1:0]  mode_ff;
   logic [10:0] width_ff, height_ff;
   logic        restart;

   assign restart = csr_write && (csr_index == pau_pkg::CSR_MODE ||
      csr_index == pau_pkg::CSR_WIDTH || csr_index == pau_pkg::CSR_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= pau_pkg::MODE_SCALE2X; width_ff <= 11'd1024; height_ff <= 11'd1024;
      end else if (csr_write) begin
         case (csr_index)
            pau_pkg::CSR_MODE:   mode_ff <= csr_data[1:0];
            pau_pkg::CSR_WIDTH:  width_ff <= csr_data;
            pau_pkg::CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic job_valid, job_full, q_ne, q_pop, f_busy, b_idle;
   pau_pkg::job_type job, head;

   pau_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_pixel_in(req_pixel_in), .cfg_restart(restart), .mode(mode_ff),
      .image_width(width_ff), .image_height(height_ff), .job_valid(job_valid),
      .job(job), .job_full(job_full), .busy(f_busy));

   pau_queue #(.DEPTH(2)) u_queue (
      .clock(clock), .reset(reset), .push(job_valid), .push_data(job), .full(job_full),
      .pop(q_pop), .not_empty(q_ne), .head(head));

   pau_back u_back (
      .clock(clock), .reset(reset), .job_ready(q_ne), .job(head), .job_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y), .rsp_pixel_out(rsp_pixel_out), .rsp_last(rsp_last),
      .idle(b_idle));

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(job_valid && job_full)) else $error("job pushed into full queue");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_ne) else $error("pop from empty queue");
   a_idle_no_out: assert property (@(posedge clock) disable iff (reset)
      (b_idle && !f_busy) |=> !rsp_valid) else $error("result without work");
endmodule
